/* hw/rtl/pid_sign_flush_integrator_unit_defines.svh */
// Assertion macros shared by the PID sign-flush integrator RTL.
`ifndef PID_SIGN_FLUSH_INTEGRATOR_UNIT_DEFINES_SVH
`define PID_SIGN_FLUSH_INTEGRATOR_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define PID_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define PID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PID_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define PID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* hw/rtl/pid_sfi_pkg.sv */
// Types and constants of the PID sign-flush integrator.
`default_nettype none

package pid_sfi_pkg;

    localparam int GAIN_FRAC_BITS_DEF = 8;
    localparam int SAMPLE_WIDTH_DEF   = 16;
    localparam int GAIN_WIDTH         = 16;
    localparam int LIMIT_WIDTH        = 24;
    localparam int DRIVE_WIDTH        = 32;
    localparam int CFG_INDEX_WIDTH    = 3;
    localparam int CFG_DATA_WIDTH     = 24;

    localparam logic POSITIVE_MARK = 1'b1;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_KP         = 3'd0,
        REG_KI         = 3'd1,
        REG_KD         = 3'd2,
        REG_INTEG_LOW  = 3'd3,
        REG_INTEG_HIGH = 3'd4
    } cfg_idx_t;

    typedef struct packed {
        logic signed [GAIN_WIDTH-1:0]  kp;
        logic signed [GAIN_WIDTH-1:0]  ki;
        logic signed [GAIN_WIDTH-1:0]  kd;
        logic signed [LIMIT_WIDTH-1:0] integ_low;
        logic signed [LIMIT_WIDTH-1:0] integ_high;
    } cfg_regs_t;

endpackage

`default_nettype wire

/* hw/rtl/pid_sfi_in_if.sv */
// Sample channel: error and position per item.
`default_nettype none

interface pid_sfi_in_if #(
    parameter int SAMPLE_WIDTH = pid_sfi_pkg::SAMPLE_WIDTH_DEF
) ();
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] err_in;
    logic signed [SAMPLE_WIDTH-1:0] pos_in;

    modport source (output valid, output err_in, output pos_in, input ready);
    modport sink   (input valid, input err_in, input pos_in, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pid_sfi_out_if.sv */
// Result channel: drive value per item.
`default_nettype none

interface pid_sfi_out_if ();
    logic                                     valid;
    logic                                     ready;
    logic signed [pid_sfi_pkg::DRIVE_WIDTH-1:0] drive;

    modport source (output valid, output drive, input ready);
    modport sink   (input valid, input drive, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pid_sfi_cfg_if.sv */
// Configuration write channel.
`default_nettype none

interface pid_sfi_cfg_if ();
    logic                                   valid;
    logic                                   ready;
    logic [pid_sfi_pkg::CFG_INDEX_WIDTH-1:0] index;
    logic [pid_sfi_pkg::CFG_DATA_WIDTH-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

/* hw/rtl/pid_sfi_cfg.sv */
// Configuration register file: gains and integrator limits.
`default_nettype none

module pid_sfi_cfg (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    pid_sfi_cfg_if.sink                 cfg,
    output pid_sfi_pkg::cfg_regs_t      regs
);

    pid_sfi_pkg::cfg_regs_t regs_reg;
    pid_sfi_pkg::cfg_regs_t regs_next;

    assign cfg.ready = 1'b1;
    assign regs      = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (cfg.valid)
        begin
            unique case (cfg.index)
                pid_sfi_pkg::REG_KP:
                    regs_next.kp = cfg.data[pid_sfi_pkg::GAIN_WIDTH-1:0];
                pid_sfi_pkg::REG_KI:
                    regs_next.ki = cfg.data[pid_sfi_pkg::GAIN_WIDTH-1:0];
                pid_sfi_pkg::REG_KD:
                    regs_next.kd = cfg.data[pid_sfi_pkg::GAIN_WIDTH-1:0];
                pid_sfi_pkg::REG_INTEG_LOW:
                    regs_next.integ_low = cfg.data[pid_sfi_pkg::LIMIT_WIDTH-1:0];
                pid_sfi_pkg::REG_INTEG_HIGH:
                    regs_next.integ_high = cfg.data[pid_sfi_pkg::LIMIT_WIDTH-1:0];
                default:
                    regs_next = regs_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg <= '0;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pid_sfi_state.sv */
// Input stage: sign-flushed integrator update, position difference.
`default_nettype none
`include "pid_sign_flush_integrator_unit_defines.svh"

module pid_sfi_state #(
    parameter int SAMPLE_WIDTH = pid_sfi_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  pid_sfi_pkg::cfg_regs_t                       regs,
    input  wire logic                                    s_valid,
    output logic                                         s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]          err,
    input  wire logic signed [SAMPLE_WIDTH-1:0]          pos,
    output logic                                         m_valid,
    input  wire logic                                    m_ready,
    output logic signed [SAMPLE_WIDTH-1:0]               err_q,
    output logic signed [pid_sfi_pkg::LIMIT_WIDTH-1:0]   integ_q,
    output logic signed [SAMPLE_WIDTH:0]                 dpos_q
);

    localparam int LW = pid_sfi_pkg::LIMIT_WIDTH;
    localparam int SW = SAMPLE_WIDTH;

    logic                 valid_reg;
    logic signed [LW-1:0] integ_acc_reg;
    logic signed [LW-1:0] integ_acc_next;
    logic signed [SW-1:0] prev_pos_reg;
    logic                 last_sign_reg;
    logic                 last_sign_next;
    logic signed [SW-1:0] err_reg;
    logic signed [SW:0]   dpos_reg;
    logic signed [SW:0]   dpos_next;

    logic                 load;
    logic                 err_pos;
    logic                 err_neg;
    logic                 flush;
    logic signed [LW-1:0] base;
    logic signed [LW:0]   acc_sum;
    logic signed [LW:0]   lo_ext;
    logic signed [LW:0]   hi_ext;

    assign s_ready = !valid_reg || m_ready;
    assign load    = s_valid && s_ready;
    assign m_valid = valid_reg;
    assign err_q   = err_reg;
    assign integ_q = integ_acc_reg;
    assign dpos_q  = dpos_reg;

    always_comb
    begin
        err_neg = err[SW-1];
        err_pos = !err[SW-1] && (err != '0);
        flush   = (err == '0) || (err_pos && (last_sign_reg != pid_sfi_pkg::POSITIVE_MARK))
                  || (err_neg && (last_sign_reg == pid_sfi_pkg::POSITIVE_MARK));
        base    = flush ? '0 : integ_acc_reg;
        acc_sum = {base[LW-1], base} + {{(LW+1-SW){err[SW-1]}}, err};
        lo_ext  = {regs.integ_low[LW-1], regs.integ_low};
        hi_ext  = {regs.integ_high[LW-1], regs.integ_high};

        // upper limit is checked first: when the limits cross, a sum above it takes the upper limit
        if (acc_sum > hi_ext)
            integ_acc_next = regs.integ_high;
        else if (acc_sum < lo_ext)
            integ_acc_next = regs.integ_low;
        else
            integ_acc_next = acc_sum[LW-1:0];

        if (err_pos)
            last_sign_next = pid_sfi_pkg::POSITIVE_MARK;
        else if (err_neg)
            last_sign_next = ~pid_sfi_pkg::POSITIVE_MARK;
        else
            last_sign_next = last_sign_reg;

        dpos_next = {pos[SW-1], pos} - {prev_pos_reg[SW-1], prev_pos_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= 1'b0;
            integ_acc_reg <= '0;
            prev_pos_reg  <= '0;
            last_sign_reg <= pid_sfi_pkg::POSITIVE_MARK;
        end
        else
        begin
            if (s_ready)
                valid_reg <= s_valid;
            if (load)
            begin
                integ_acc_reg <= integ_acc_next;
                prev_pos_reg  <= pos;
                last_sign_reg <= last_sign_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            err_reg  <= err;
            dpos_reg <= dpos_next;
        end
    end

    `PID_ASSERT_IMPLY(a_integ_in_limits, clk, rst_n,
        $past(rst_n) && $past(load) && $past(regs.integ_low <= regs.integ_high),
        integ_acc_reg <= $past(regs.integ_high) && integ_acc_reg >= $past(regs.integ_low),
        "integrator left its limits")
    `PID_ASSERT_IMPLY(a_sign_tracks_err, clk, rst_n,
        $past(rst_n) && $past(load) && $past(err != '0),
        last_sign_reg == !$past(err[SW-1]),
        "sign mark does not follow nonzero error")
    `PID_ASSERT_IMPLY(a_state_holds_idle, clk, rst_n,
        $past(rst_n) && !$past(load),
        $stable(integ_acc_reg) && $stable(prev_pos_reg) && $stable(last_sign_reg),
        "state changed without an item")

endmodule

`default_nettype wire

/* hw/rtl/pid_sfi_mul.sv */
// Product stage: the three gain multiplies, registered.
`default_nettype none

module pid_sfi_mul #(
    parameter int SAMPLE_WIDTH = pid_sfi_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  pid_sfi_pkg::cfg_regs_t                            regs,
    input  wire logic                                         s_valid,
    output logic                                              s_ready,
    input  wire logic signed [SAMPLE_WIDTH-1:0]               err,
    input  wire logic signed [pid_sfi_pkg::LIMIT_WIDTH-1:0]   integ,
    input  wire logic signed [SAMPLE_WIDTH:0]                 dpos,
    output logic                                              m_valid,
    input  wire logic                                         m_ready,
    output logic signed [pid_sfi_pkg::GAIN_WIDTH+SAMPLE_WIDTH-1:0]          p_q,
    output logic signed [pid_sfi_pkg::GAIN_WIDTH+pid_sfi_pkg::LIMIT_WIDTH-1:0] i_q,
    output logic signed [pid_sfi_pkg::GAIN_WIDTH+SAMPLE_WIDTH:0]            d_q
);

    localparam int PW = pid_sfi_pkg::GAIN_WIDTH + SAMPLE_WIDTH;
    localparam int IW = pid_sfi_pkg::GAIN_WIDTH + pid_sfi_pkg::LIMIT_WIDTH;
    localparam int DW = pid_sfi_pkg::GAIN_WIDTH + SAMPLE_WIDTH + 1;

    logic                 valid_reg;
    logic                 load;
    logic signed [PW-1:0] p_reg;
    logic signed [PW-1:0] p_next;
    logic signed [IW-1:0] i_reg;
    logic signed [IW-1:0] i_next;
    logic signed [DW-1:0] d_reg;
    logic signed [DW-1:0] d_next;

    assign s_ready = !valid_reg || m_ready;
    assign load    = s_valid && s_ready;
    assign m_valid = valid_reg;
    assign p_q     = p_reg;
    assign i_q     = i_reg;
    assign d_q     = d_reg;

    always_comb
    begin
        p_next = PW'($signed(regs.kp)) * PW'(err);
        i_next = IW'($signed(regs.ki)) * IW'(integ);
        d_next = DW'($signed(regs.kd)) * DW'(dpos);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            p_reg <= p_next;
            i_reg <= i_next;
            d_reg <= d_next;
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/pid_sfi_out.sv */
// Output stages: sum of terms, truncation toward zero, 32-bit saturation.
`default_nettype none

module pid_sfi_out #(
    parameter int SAMPLE_WIDTH   = pid_sfi_pkg::SAMPLE_WIDTH_DEF,
    parameter int GAIN_FRAC_BITS = pid_sfi_pkg::GAIN_FRAC_BITS_DEF
) (
    input  wire logic                                                          clk,
    input  wire logic                                                          rst_n,
    input  wire logic                                                          s_valid,
    output logic                                                               s_ready,
    input  wire logic signed [pid_sfi_pkg::GAIN_WIDTH+SAMPLE_WIDTH-1:0]          p,
    input  wire logic signed [pid_sfi_pkg::GAIN_WIDTH+pid_sfi_pkg::LIMIT_WIDTH-1:0] i,
    input  wire logic signed [pid_sfi_pkg::GAIN_WIDTH+SAMPLE_WIDTH:0]            d,
    pid_sfi_out_if.source                                                      results
);

    localparam int DRW  = pid_sfi_pkg::DRIVE_WIDTH;
    localparam int SUMW = pid_sfi_pkg::GAIN_WIDTH + pid_sfi_pkg::LIMIT_WIDTH + 3;
    localparam logic signed [SUMW-1:0] BIAS =
        (SUMW'(1) << GAIN_FRAC_BITS) - SUMW'(1);
    localparam logic signed [SUMW-1:0] SAT_HI =
        {{(SUMW-DRW+1){1'b0}}, {(DRW-1){1'b1}}};
    localparam logic signed [SUMW-1:0] SAT_LO =
        {{(SUMW-DRW+1){1'b1}}, {(DRW-1){1'b0}}};

    logic                   sum_valid_reg;
    logic signed [SUMW-1:0] sum_reg;
    logic signed [SUMW-1:0] sum_next;
    logic                   sum_ready;
    logic                   sum_load;
    logic                   drive_valid_reg;
    logic signed [DRW-1:0]  drive_reg;
    logic signed [DRW-1:0]  drive_next;
    logic                   drive_load;
    logic signed [SUMW-1:0] biased;
    logic signed [SUMW-1:0] quot;

    assign s_ready   = !sum_valid_reg || sum_ready;
    assign sum_load  = s_valid && s_ready;
    assign sum_ready = !drive_valid_reg || results.ready;
    assign drive_load = sum_valid_reg && sum_ready;

    assign results.valid = drive_valid_reg;
    assign results.drive = drive_reg;

    always_comb
    begin
        sum_next = SUMW'(p) + SUMW'(i) + SUMW'(d);

        biased = sum_reg[SUMW-1] ? (sum_reg + BIAS) : sum_reg;
        quot   = biased >>> GAIN_FRAC_BITS;
        if (quot > SAT_HI)
            drive_next = SAT_HI[DRW-1:0];
        else if (quot < SAT_LO)
            drive_next = SAT_LO[DRW-1:0];
        else
            drive_next = quot[DRW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_valid_reg   <= 1'b0;
            drive_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_ready)
                sum_valid_reg <= s_valid;
            if (sum_ready)
                drive_valid_reg <= sum_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sum_load)
            sum_reg <= sum_next;
        if (drive_load)
            drive_reg <= drive_next;
    end

endmodule

`default_nettype wire

/* hw/rtl/pid_sign_flush_integrator_unit.sv */
// Top level of the PID sign-flush integrator.
//
//  channel   role   payload                    accepted when
//  samples   sink   err_in, pos_in             valid && ready
//  results   source drive                      valid && ready
//  cfg       sink   index, data                valid && ready (ready tied high)
//
// One item per cycle unless results.ready is held low; four register stages (state update,
// multiplies, sum, truncate/saturate) lie between an accepted sample and its drive item.
// The integrator update closes in the input stage.
// Reset clears gains, limits, integrator, previous position; sign mark positive.
// A stalled result stalls the pipe one stage at a time; samples.ready drops only
// when every stage is full and results.ready is low.
`default_nettype none
`include "pid_sign_flush_integrator_unit_defines.svh"

module pid_sign_flush_integrator_unit #(
    parameter int GAIN_FRAC_BITS = pid_sfi_pkg::GAIN_FRAC_BITS_DEF,
    parameter int SAMPLE_WIDTH   = pid_sfi_pkg::SAMPLE_WIDTH_DEF
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    pid_sfi_in_if.sink      samples,
    pid_sfi_out_if.source   results,
    pid_sfi_cfg_if.sink     cfg
);

    localparam int LW = pid_sfi_pkg::LIMIT_WIDTH;
    localparam int GW = pid_sfi_pkg::GAIN_WIDTH;

    pid_sfi_pkg::cfg_regs_t regs;

    logic                          st_valid;
    logic                          st_ready;
    logic signed [SAMPLE_WIDTH-1:0] st_err;
    logic signed [LW-1:0]          st_integ;
    logic signed [SAMPLE_WIDTH:0]  st_dpos;

    logic                             mul_valid;
    logic                             mul_ready;
    logic signed [GW+SAMPLE_WIDTH-1:0] mul_p;
    logic signed [GW+LW-1:0]          mul_i;
    logic signed [GW+SAMPLE_WIDTH:0]  mul_d;

    pid_sfi_cfg u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .regs  (regs)
    );

    pid_sfi_state #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_state (
        .clk     (clk),
        .rst_n   (rst_n),
        .regs    (regs),
        .s_valid (samples.valid),
        .s_ready (samples.ready),
        .err     (samples.err_in),
        .pos     (samples.pos_in),
        .m_valid (st_valid),
        .m_ready (st_ready),
        .err_q   (st_err),
        .integ_q (st_integ),
        .dpos_q  (st_dpos)
    );

    pid_sfi_mul #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .regs    (regs),
        .s_valid (st_valid),
        .s_ready (st_ready),
        .err     (st_err),
        .integ   (st_integ),
        .dpos    (st_dpos),
        .m_valid (mul_valid),
        .m_ready (mul_ready),
        .p_q     (mul_p),
        .i_q     (mul_i),
        .d_q     (mul_d)
    );

    pid_sfi_out #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
    ) u_out (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_valid (mul_valid),
        .s_ready (mul_ready),
        .p       (mul_p),
        .i       (mul_i),
        .d       (mul_d),
        .results (results)
    );

    `PID_ASSERT_IMPLY(a_stall_only_when_blocked, clk, rst_n,
        !samples.ready,
        results.valid && !results.ready && st_valid && mul_valid,
        "input stalled while output side could move")

endmodule

`default_nettype wire
